// ----- hdl/point_rotation_by_degrees_core_macros.svh -----
// Assertion macros used by the bound prd_checker module.
`ifndef POINT_ROTATION_BY_DEGREES_CORE_MACROS_SVH
`define POINT_ROTATION_BY_DEGREES_CORE_MACROS_SVH

// a implies b in the same cycle
`define PRD_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// a implies b a fixed number of cycles later
`define PRD_ASSERT_DELAY(lbl, clk, rst_n, a, dly, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##dly (b)) \
        else $error("delayed check failed");

// a must never hold
`define PRD_ASSERT_NEVER(lbl, clk, rst_n, a) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("forbidden condition seen");

`endif

// ----- hdl/prd_pkg.sv -----
`default_nettype none

package prd_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int TABLE_LEN    = 91;
    localparam int DEG_FULL     = 360;
    // angle + 2^15 is 8 above a multiple of 360; adding 352 keeps the residue
    localparam int MOD_OFFSET   = 352;
    localparam int MOD_RECIP    = 46604;
    localparam int MOD_SHIFT    = 24;
    localparam int PIPE_LATENCY = 5;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // sin(k degrees) in Q30 by an integer Taylor series; elaboration only
    function automatic logic [63:0] sine_q30(input logic [6:0] k);
        logic        [63:0] th;
        logic        [63:0] th2;
        logic        [63:0] term;
        logic signed [63:0] acc;
        th   = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
        th2  = (th * th) >> 30;
        term = th;
        acc  = $signed(th);
        // twelve terms, each divided by (2n)(2n+1), alternating sign
        term = ((term * th2) >> 30) / 64'd6;
        acc  = acc - $signed(term);
        term = ((term * th2) >> 30) / 64'd20;
        acc  = acc + $signed(term);
        term = ((term * th2) >> 30) / 64'd42;
        acc  = acc - $signed(term);
        term = ((term * th2) >> 30) / 64'd72;
        acc  = acc + $signed(term);
        term = ((term * th2) >> 30) / 64'd110;
        acc  = acc - $signed(term);
        term = ((term * th2) >> 30) / 64'd156;
        acc  = acc + $signed(term);
        term = ((term * th2) >> 30) / 64'd210;
        acc  = acc - $signed(term);
        term = ((term * th2) >> 30) / 64'd272;
        acc  = acc + $signed(term);
        term = ((term * th2) >> 30) / 64'd342;
        acc  = acc - $signed(term);
        term = ((term * th2) >> 30) / 64'd420;
        acc  = acc + $signed(term);
        term = ((term * th2) >> 30) / 64'd506;
        acc  = acc - $signed(term);
        term = ((term * th2) >> 30) / 64'd600;
        acc  = acc + $signed(term);
        if (acc < 0) begin
            acc = '0;
        end
        return $unsigned(acc);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/point_rotation_by_degrees_core.sv -----
// Channel  | Handshake        | Ports
// ---------+------------------+-------------------------------------
// item in  | start && !busy   | i_x_in, i_y_in, i_angle_deg
// item out | o_done (1 cycle) | o_x_out, o_y_out
//
// Five-stage pipeline: input register, angle reduction, sine/cosine lookup,
// four products, and sum and round into the result register. One item per cycle.
// busy stays low; the pipeline never holds and the receiver cannot stall.
// Reset clears only the stage valid bits.
`default_nettype none

module point_rotation_by_degrees_core
    import prd_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_x_in,
    input  wire logic signed [COORD_WIDTH-1:0] i_y_in,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_angle_deg,
    output logic                               o_done,
    output logic signed [COORD_WIDTH:0]        o_x_out,
    output logic signed [COORD_WIDTH:0]        o_y_out
);

    localparam int CW = FRACTION_BITS + 2;              // signed sin/cos
    localparam int PW = COORD_WIDTH + FRACTION_BITS + 2; // product
    localparam int AW = PW + 1;                         // sum

    typedef logic [FRACTION_BITS:0] t_tab [TABLE_LEN];

    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] s;
        logic [63:0] r;
        for (int k = 0; k < TABLE_LEN; k++) begin
            s = sine_q30(7'(k));
            r = (s + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
            if (r > (64'd1 << FRACTION_BITS)) begin
                r = 64'd1 << FRACTION_BITS;
            end
            tab[k] = r[FRACTION_BITS:0];
        end
        tab[0]             = '0;
        tab[TABLE_LEN - 1] = {1'b1, {FRACTION_BITS{1'b0}}};
        return tab;
    endfunction

    localparam t_tab SIN_TAB = build_tab();

    // stage 0: input register
    logic                          r_v0;
    logic signed [COORD_WIDTH-1:0] r_x0, r_y0;
    logic        [ANGLE_WIDTH-1:0] r_a0;
    // stage 1: reduced angle
    logic                          r_v1;
    logic signed [COORD_WIDTH-1:0] r_x1, r_y1;
    logic        [8:0]             r_a1;
    // stage 2: sine and cosine
    logic                          r_v2;
    logic signed [COORD_WIDTH-1:0] r_x2, r_y2;
    logic signed [CW-1:0]          r_s2, r_c2;
    // stage 3: products
    logic                          r_v3;
    logic signed [PW-1:0]          r_xc3, r_ys3, r_yc3, r_xs3;

    logic        [16:0] n_u;
    logic        [32:0] n_prod;
    logic        [7:0]  n_q;
    logic        [16:0] n_rem;
    logic        [8:0]  n_a1;
    logic        [8:0]  n_is, n_ic;
    logic               n_neg_s, n_neg_c;
    logic signed [CW-1:0] n_s2, n_c2;
    logic signed [AW-1:0] n_accx, n_accy, n_sumx, n_sumy;

    assign busy = 1'b0;

    // angle mod 360 by reciprocal multiply and one correction
    always_comb begin
        n_u    = {1'b0, ~r_a0[ANGLE_WIDTH-1], r_a0[ANGLE_WIDTH-2:0]} + 17'(MOD_OFFSET);
        n_prod = 33'(n_u) * 33'(MOD_RECIP);
        n_q    = n_prod[MOD_SHIFT +: 8];
        n_rem  = n_u - 17'(n_q * 17'(DEG_FULL));
        if (n_rem >= 17'(DEG_FULL)) begin
            n_rem = n_rem - 17'(DEG_FULL);
        end
        n_a1 = n_rem[8:0];
    end

    // quadrant fold onto the quarter-wave table
    always_comb begin
        if (r_a1 <= 9'd90) begin
            n_is = r_a1;           n_ic = 9'd90 - r_a1;
            n_neg_s = 1'b0;        n_neg_c = 1'b0;
        end else if (r_a1 <= 9'd180) begin
            n_is = 9'd180 - r_a1;  n_ic = r_a1 - 9'd90;
            n_neg_s = 1'b0;        n_neg_c = 1'b1;
        end else if (r_a1 <= 9'd270) begin
            n_is = r_a1 - 9'd180;  n_ic = 9'd270 - r_a1;
            n_neg_s = 1'b1;        n_neg_c = 1'b1;
        end else begin
            n_is = 9'd360 - r_a1;  n_ic = r_a1 - 9'd270;
            n_neg_s = 1'b1;        n_neg_c = 1'b0;
        end
        n_s2 = $signed({1'b0, SIN_TAB[n_is[6:0]]});
        n_c2 = $signed({1'b0, SIN_TAB[n_ic[6:0]]});
        if (n_neg_s) begin
            n_s2 = -n_s2;
        end
        if (n_neg_c) begin
            n_c2 = -n_c2;
        end
    end

    // round to nearest, ties away from zero: (acc + half - neg) >>> F
    always_comb begin
        n_accx = AW'(r_xc3) + AW'(r_ys3);
        n_accy = AW'(r_yc3) - AW'(r_xs3);
        n_sumx = n_accx + AW'(signed'({1'b0, 1'b1, {(FRACTION_BITS-1){1'b0}}}))
                 - AW'(signed'({1'b0, n_accx[AW-1]}));
        n_sumy = n_accy + AW'(signed'({1'b0, 1'b1, {(FRACTION_BITS-1){1'b0}}}))
                 - AW'(signed'({1'b0, n_accy[AW-1]}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v0   <= start && !busy;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            o_done <= r_v3;
        end
        r_x0  <= i_x_in;
        r_y0  <= i_y_in;
        r_a0  <= i_angle_deg;
        r_x1  <= r_x0;
        r_y1  <= r_y0;
        r_a1  <= n_a1;
        r_x2  <= r_x1;
        r_y2  <= r_y1;
        r_s2  <= n_s2;
        r_c2  <= n_c2;
        r_xc3 <= PW'(r_x2) * PW'(r_c2);
        r_ys3 <= PW'(r_y2) * PW'(r_s2);
        r_yc3 <= PW'(r_y2) * PW'(r_c2);
        r_xs3 <= PW'(r_x2) * PW'(r_s2);
        o_x_out <= n_sumx[FRACTION_BITS +: COORD_WIDTH + 1];
        o_y_out <= n_sumy[FRACTION_BITS +: COORD_WIDTH + 1];
    end

endmodule

`default_nettype wire

// ----- hdl/prd_checker.sv -----
`default_nettype none

`include "point_rotation_by_degrees_core_macros.svh"

module prd_checker
    import prd_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic signed [COORD_WIDTH-1:0] i_x_in,
    input wire logic signed [COORD_WIDTH-1:0] i_y_in,
    input wire logic signed [ANGLE_WIDTH-1:0] i_angle_deg,
    input wire logic                          o_done,
    input wire logic signed [COORD_WIDTH:0]   o_x_out,
    input wire logic signed [COORD_WIDTH:0]   o_y_out
);

    `PRD_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy)

    `PRD_ASSERT_DELAY(a_item_done, i_clk, i_rst_n, start && !busy, PIPE_LATENCY, o_done)

    `PRD_ASSERT_IMPLY(a_done_had_item, i_clk, i_rst_n, o_done, $past(start && !busy, PIPE_LATENCY))

    // zero rotation passes the point through unchanged
    `PRD_ASSERT_DELAY(a_zero_angle, i_clk, i_rst_n, start && !busy && i_angle_deg == '0, PIPE_LATENCY, o_x_out == {$past(i_x_in[COORD_WIDTH-1], PIPE_LATENCY), $past(i_x_in, PIPE_LATENCY)} && o_y_out == {$past(i_y_in[COORD_WIDTH-1], PIPE_LATENCY), $past(i_y_in, PIPE_LATENCY)})

endmodule

bind point_rotation_by_degrees_core prd_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_prd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_x_in     (i_x_in),
    .i_y_in     (i_y_in),
    .i_angle_deg(i_angle_deg),
    .o_done     (o_done),
    .o_x_out    (o_x_out),
    .o_y_out    (o_y_out)
);

`default_nettype wire

// ----- dv/point_rotation_by_degrees_core_checker.sv -----
module point_rotation_by_degrees_core_checker
    import prd_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_x_in,
    input  wire logic signed [COORD_WIDTH-1:0] i_y_in,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_angle_deg,
    input  wire logic                          i_done,
    input  wire logic signed [COORD_WIDTH:0]   i_x_out,
    input  wire logic signed [COORD_WIDTH:0]   i_y_out,
    output int                                 o_fail_count,
    output int                                 o_open_count,
    output int                                 o_match_count
);

    localparam longint unsigned RAD_PI_Q30 = 64'd3373259426;
    localparam int              QUARTER    = 90;
    localparam longint          ROUND_HALF = longint'(1) << (FRACTION_BITS - 1);

    typedef struct packed {
        logic signed [COORD_WIDTH:0] xr;
        logic signed [COORD_WIDTH:0] yr;
    } t_rotated;

    longint   sine_lut [0:QUARTER];
    t_rotated rotated_q [$];
    int       fail_total  = 0;
    int       match_total = 0;

    // sin(deg) in Q30 from a truncated Taylor series in integer arithmetic
    function automatic longint unsigned taylor_sine_q30(input int unsigned deg);
        longint unsigned theta;
        longint unsigned theta_sq;
        longint unsigned term;
        longint unsigned divisor;
        longint          acc;
        theta    = (longint'(deg) * RAD_PI_Q30 + 64'd90) / 64'd180;
        theta_sq = (theta * theta) >> 30;
        term     = theta;
        acc      = longint'(theta);
        for (int n = 1; n <= 12; n++) begin
            divisor = longint'(2 * n) * longint'(2 * n + 1);
            term    = ((term * theta_sq) >> 30) / divisor;
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return longint'(acc);
    endfunction

    initial begin
        longint unsigned q30;
        longint unsigned lut_val;
        for (int k = 0; k <= QUARTER; k++) begin
            q30     = taylor_sine_q30(k);
            lut_val = (q30 + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
            if (lut_val > (64'd1 << FRACTION_BITS)) begin
                lut_val = 64'd1 << FRACTION_BITS;
            end
            sine_lut[k] = longint'(lut_val);
        end
        // pin the axes exactly
        sine_lut[0]       = 0;
        sine_lut[QUARTER] = longint'(1) << FRACTION_BITS;
    end

    // round to nearest integer, ties away from zero
    function automatic longint round_half_away(input longint acc);
        if (acc >= 0) begin
            return (acc + ROUND_HALF) >>> FRACTION_BITS;
        end
        return -((-acc + ROUND_HALF) >>> FRACTION_BITS);
    endfunction

    function automatic t_rotated rotate_point(
        input logic signed [COORD_WIDTH-1:0] px,
        input logic signed [COORD_WIDTH-1:0] py,
        input logic signed [ANGLE_WIDTH-1:0] pa
    );
        int       deg;
        longint   sin_v;
        longint   cos_v;
        longint   sum_x;
        longint   sum_y;
        t_rotated res;
        deg = int'(pa) % DEG_FULL;
        if (deg < 0) begin
            deg = deg + DEG_FULL;
        end
        if (deg <= 90) begin
            sin_v = sine_lut[deg];
            cos_v = sine_lut[90 - deg];
        end else if (deg <= 180) begin
            sin_v = sine_lut[180 - deg];
            cos_v = -sine_lut[deg - 90];
        end else if (deg <= 270) begin
            sin_v = -sine_lut[deg - 180];
            cos_v = -sine_lut[270 - deg];
        end else begin
            sin_v = -sine_lut[360 - deg];
            cos_v = sine_lut[deg - 270];
        end
        sum_x  = longint'(px) * cos_v + longint'(py) * sin_v;
        sum_y  = longint'(py) * cos_v - longint'(px) * sin_v;
        res.xr = (COORD_WIDTH + 1)'(round_half_away(sum_x));
        res.yr = (COORD_WIDTH + 1)'(round_half_away(sum_y));
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rotated want;
        if (i_rst_n) begin
            if (i_done) begin
                if (rotated_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result x_out %0d y_out %0d, nothing pending",
                             $time, i_x_out, i_y_out);
                end else begin
                    want = rotated_q.pop_front();
                    match_total++;
                    if (i_x_out !== want.xr) begin
                        fail_total++;
                        $display("%0t: x_out mismatch, expected %0d, got %0d",
                                 $time, want.xr, i_x_out);
                    end
                    if (i_y_out !== want.yr) begin
                        fail_total++;
                        $display("%0t: y_out mismatch, expected %0d, got %0d",
                                 $time, want.yr, i_y_out);
                    end
                end
            end
            if (i_start && !i_busy) begin
                rotated_q.push_back(rotate_point(i_x_in, i_y_in, i_angle_deg));
            end
        end
        o_fail_count  <= fail_total;
        o_open_count  <= rotated_q.size();
        o_match_count <= match_total;
    end

endmodule

// ----- dv/point_rotation_by_degrees_core_test.sv -----
module point_rotation_by_degrees_core_test;
    import prd_pkg::*;

    localparam int COORD_WIDTH   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int PHASE_POINTS  = 375;
    localparam int STALL_LIMIT   = 4000;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic signed [COORD_WIDTH-1:0] i_x_in      = '0;
    logic signed [COORD_WIDTH-1:0] i_y_in      = '0;
    logic signed [ANGLE_WIDTH-1:0] i_angle_deg = '0;
    logic                          busy;
    logic                          o_done;
    logic signed [COORD_WIDTH:0]   o_x_out;
    logic signed [COORD_WIDTH:0]   o_y_out;

    int fail_count;
    int open_count;
    int match_count;
    int sent_count = 0;
    int quiet_run  = 0;

    point_rotation_by_degrees_core #(
        .COORD_WIDTH  (COORD_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_x_in     (i_x_in),
        .i_y_in     (i_y_in),
        .i_angle_deg(i_angle_deg),
        .o_done     (o_done),
        .o_x_out    (o_x_out),
        .o_y_out    (o_y_out)
    );

    point_rotation_by_degrees_core_checker #(
        .COORD_WIDTH  (COORD_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_x_in       (i_x_in),
        .i_y_in       (i_y_in),
        .i_angle_deg  (i_angle_deg),
        .i_done       (o_done),
        .i_x_out      (o_x_out),
        .i_y_out      (o_y_out),
        .o_fail_count (fail_count),
        .o_open_count (open_count),
        .o_match_count(match_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hold start until the item is taken
    task automatic send_point(
        input logic signed [COORD_WIDTH-1:0] px,
        input logic signed [COORD_WIDTH-1:0] py,
        input logic signed [ANGLE_WIDTH-1:0] pa
    );
        start       <= 1'b1;
        i_x_in      <= px;
        i_y_in      <= py;
        i_angle_deg <= pa;
        do @(posedge i_clk); while (busy);
        sent_count++;
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(15))
            0:       return {1'b1, {(COORD_WIDTH - 1){1'b0}}};
            1:       return {1'b0, {(COORD_WIDTH - 1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4:       return COORD_WIDTH'($urandom_range(16)) - COORD_WIDTH'(8);
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic signed [ANGLE_WIDTH-1:0] pick_angle();
        case ($urandom_range(7))
            0, 1:    return ANGLE_WIDTH'(90 * (int'($urandom_range(728)) - 364));
            2, 3:    return ANGLE_WIDTH'(int'($urandom_range(1440)) - 720);
            default: return ANGLE_WIDTH'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_run <= 0;
        end else if (quiet_run >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_run <= quiet_run + 1;
        end
    end

    initial begin
        int idle_pct [4];
        int directed_count;
        idle_pct = '{0, 64, 0, 26};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // axes, angle wrap, field extremes, largest magnitudes, half ties
        send_point(16'sd100, 16'sd0, 16'sd0);
        send_point(16'sd100, 16'sd0, 16'sd90);
        send_point(16'sd100, 16'sd0, 16'sd180);
        send_point(16'sd100, 16'sd0, 16'sd270);
        send_point(16'sd100, 16'sd0, 16'sd360);
        send_point(16'sd100, -16'sd7, -16'sd90);
        send_point(16'sd100, 16'sd3, -16'sd360);
        send_point(16'sd1000, -16'sd500, 16'sd32767);
        send_point(16'sd1000, -16'sd500, -16'sd32768);
        send_point(16'sd12345, -16'sd321, -16'sd1);
        send_point(-16'sd32768, -16'sd32768, 16'sd45);
        send_point(16'sd32767, 16'sd32767, 16'sd45);
        send_point(-16'sd32768, 16'sd32767, 16'sd135);
        send_point(16'sd32767, -16'sd32768, 16'sd315);
        send_point(-16'sd32768, -16'sd32768, 16'sd225);
        send_point(16'sd0, 16'sd1, 16'sd30);
        send_point(16'sd0, -16'sd1, 16'sd30);
        send_point(16'sd1, 16'sd0, 16'sd60);
        send_point(-16'sd1, 16'sd0, 16'sd60);
        send_point(16'sd3, -16'sd1, 16'sd210);
        send_point(16'sd32767, -16'sd32768, 16'sd359);
        send_point(-16'sd32768, 16'sd0, 16'sd1);
        send_point(16'sd0, 16'sd32767, 16'sd89);
        send_point(16'sd7, -16'sd7, 16'sd719);
        directed_count = sent_count;

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < PHASE_POINTS; n++) begin
                idle_gap(idle_pct[ph]);
                send_point(pick_coord(), pick_coord(), pick_angle());
            end
        end
        start <= 1'b0;

        while (open_count != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        $display("rotated %0d points (%0d directed: axes, wrap, extremes, half ties)",
                 sent_count, directed_count);
        $display("%0d results compared over four sender pacing phases, %0d field errors",
                 match_count, fail_count);
        if (fail_count == 0 && open_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
